FILE: sv/blkd_pkg.sv
// shared types and constants for the brake light detector
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps
`default_nettype none

package blkd_pkg;

    localparam int SPEED_W = 16;
    localparam int TIME_W  = 32;
    localparam int ZONE_W  = 15;
    localparam int MS_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEAD_ZONE      = 2'd0,
        CFG_DROP_THRESHOLD = 2'd1,
        CFG_HOLD_MS        = 2'd2,
        CFG_DEBOUNCE_MS    = 2'd3
    } t_cfg_idx;

    localparam logic [ZONE_W-1:0] DEAD_ZONE_RST      = 15'd0;
    localparam logic [ZONE_W-1:0] DROP_THRESHOLD_RST = 15'd13;
    localparam logic [MS_W-1:0]   HOLD_MS_RST        = 16'd500;
    localparam logic [MS_W-1:0]   DEBOUNCE_MS_RST    = 16'd50;

    typedef struct packed {
        logic [ZONE_W-1:0] dead_zone;
        logic [ZONE_W-1:0] drop_threshold;
        logic [MS_W-1:0]   hold_ms;
        logic [MS_W-1:0]   debounce_ms;
    } t_cfg;

    typedef struct packed {
        logic light_on;
        logic light_changed;
        logic braking_seen;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/brake_light_detector_core.sv
// brake light detector top level: input register, evaluation, result register
// depends on blkd_pkg, blkd_cfg_regs, blkd_eval
`timescale 1ns / 1ps
`default_nettype none

// Takes one speed sample (signed Q8.8) with its millisecond timestamp per
// transfer and returns exactly one result per sample: the shown brake light,
// whether this sample changed it, and whether the sample counted as braking.
// Sustained rate is one sample per clock while the output is not stalled; a
// sample passes the input register and then the result register on its way
// to the output, with the single compare-and-subtract pass between them.
// Each register absorbs one item while the next stage stalls. Configuration
// writes take effect on the next cycle and should only be issued while no
// sample is in flight.
module brake_light_detector_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [blkd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [blkd_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic signed [blkd_pkg::SPEED_W-1:0]  i_speed,
    input  wire logic [blkd_pkg::TIME_W-1:0]          i_now_ms,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic                                      o_light_on,
    output logic                                      o_light_changed,
    output logic                                      o_braking_seen
);

    blkd_pkg::t_cfg    cfg;
    blkd_pkg::t_result res;

    logic                                r_in_valid;
    logic signed [blkd_pkg::SPEED_W-1:0] r_speed;
    logic [blkd_pkg::TIME_W-1:0]         r_now_ms;
    logic                                r_out_valid;
    blkd_pkg::t_result                   r_res;

    logic fire;
    logic in_take;

    // item moves from input register to result register
    assign fire    = r_in_valid && !(r_out_valid && i_out_stall);
    assign in_take = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !fire;

    blkd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    blkd_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (fire),
        .i_speed  (r_speed),
        .i_now_ms (r_now_ms),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_speed  <= i_speed;
            r_now_ms <= i_now_ms;
        end
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_light_on      = r_res.light_on;
    assign o_light_changed = r_res.light_changed;
    assign o_braking_seen  = r_res.braking_seen;

endmodule

`default_nettype wire

FILE: sv/blkd_cfg_regs.sv
// configuration register file of the brake light detector
// depends on blkd_pkg
`timescale 1ns / 1ps
`default_nettype none

module blkd_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [blkd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [blkd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output blkd_pkg::t_cfg                        o_cfg
);

    blkd_pkg::t_cfg r_cfg;
    blkd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (blkd_pkg::t_cfg_idx'(i_cfg_idx))
                blkd_pkg::CFG_DEAD_ZONE:
                    n_cfg.dead_zone = i_cfg_wdata[blkd_pkg::ZONE_W-1:0];
                blkd_pkg::CFG_DROP_THRESHOLD:
                    n_cfg.drop_threshold = i_cfg_wdata[blkd_pkg::ZONE_W-1:0];
                blkd_pkg::CFG_HOLD_MS:
                    n_cfg.hold_ms = i_cfg_wdata[blkd_pkg::MS_W-1:0];
                blkd_pkg::CFG_DEBOUNCE_MS:
                    n_cfg.debounce_ms = i_cfg_wdata[blkd_pkg::MS_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_zone      <= blkd_pkg::DEAD_ZONE_RST;
            r_cfg.drop_threshold <= blkd_pkg::DROP_THRESHOLD_RST;
            r_cfg.hold_ms        <= blkd_pkg::HOLD_MS_RST;
            r_cfg.debounce_ms    <= blkd_pkg::DEBOUNCE_MS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: sv/blkd_eval.sv
// braking classification, hold timer and debounced light state
// depends on blkd_pkg; state advances once per item moved to the result register
`timescale 1ns / 1ps
`default_nettype none

module blkd_eval (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  blkd_pkg::t_cfg                            i_cfg,
    input  wire logic                                 i_fire,
    input  wire logic signed [blkd_pkg::SPEED_W-1:0]  i_speed,
    input  wire logic [blkd_pkg::TIME_W-1:0]          i_now_ms,
    output blkd_pkg::t_result                         o_res
);

    localparam int SPEED_W = blkd_pkg::SPEED_W;
    localparam int TIME_W  = blkd_pkg::TIME_W;
    localparam int ZONE_W  = blkd_pkg::ZONE_W;
    localparam int MS_W    = blkd_pkg::MS_W;

    logic signed [SPEED_W-1:0] r_prev_speed;
    logic                      r_shown;
    logic [TIME_W-1:0]         r_last_change;
    logic [TIME_W-1:0]         r_brake_time;

    logic [SPEED_W:0]   cur_ext;
    logic [SPEED_W:0]   prev_ext;
    logic [SPEED_W:0]   abs_cur;
    logic [SPEED_W:0]   abs_prev;
    logic [SPEED_W+1:0] cur_plus_drop;
    logic               dropped;
    logic               reversed;
    logic               moving;
    logic               braking;
    logic [TIME_W-1:0]  n_brake_time;
    logic [TIME_W-1:0]  since_brake;
    logic [TIME_W-1:0]  since_change;
    logic               request;
    logic               change;

    // magnitudes one bit wider so that the most negative sample stays exact
    always_comb begin
        cur_ext  = {i_speed[SPEED_W-1], i_speed};
        prev_ext = {r_prev_speed[SPEED_W-1], r_prev_speed};
        abs_cur  = cur_ext[SPEED_W] ? (~cur_ext + 1'b1) : cur_ext;
        abs_prev = prev_ext[SPEED_W] ? (~prev_ext + 1'b1) : prev_ext;

        cur_plus_drop = {1'b0, abs_cur} + {{(SPEED_W+2-ZONE_W){1'b0}}, i_cfg.drop_threshold};
        dropped  = cur_plus_drop < {1'b0, abs_prev};
        reversed = !r_prev_speed[SPEED_W-1] && (r_prev_speed != '0) && i_speed[SPEED_W-1];
        moving   = abs_prev > {{(SPEED_W+1-ZONE_W){1'b0}}, i_cfg.dead_zone};
        braking  = (dropped || reversed) && moving;

        n_brake_time = braking ? i_now_ms : r_brake_time;
        since_brake  = i_now_ms - n_brake_time;
        since_change = i_now_ms - r_last_change;
        request = since_brake < {{(TIME_W-MS_W){1'b0}}, i_cfg.hold_ms};
        change  = (request != r_shown)
                  && (since_change > {{(TIME_W-MS_W){1'b0}}, i_cfg.debounce_ms});

        o_res.light_on      = change ? request : r_shown;
        o_res.light_changed = change;
        o_res.braking_seen  = braking;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_speed  <= '0;
            r_shown       <= 1'b0;
            r_last_change <= '0;
            r_brake_time  <= '0;
        end else if (i_fire) begin
            r_prev_speed <= i_speed;
            r_brake_time <= n_brake_time;
            if (change) begin
                r_shown       <= request;
                r_last_change <= i_now_ms;
            end
        end
    end

    // shown state only moves together with the change flag
    a_shown_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !o_res.light_changed |=> r_shown == $past(r_shown))
        else $error("shown state moved without a change flag");

    a_change_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.light_changed |=> r_last_change == $past(i_now_ms)
            && r_shown == $past(o_res.light_on))
        else $error("change time or shown state not captured");

    a_brake_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.braking_seen |=> r_brake_time == $past(i_now_ms))
        else $error("hold timer not restarted on braking");

    a_idle_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_prev_speed) && $stable(r_shown) && $stable(r_brake_time))
        else $error("state changed without an item");

endmodule

`default_nettype wire
